// File: sv/pexp_pkg.sv
`default_nettype none
package pexp_pkg;

  // Field widths
  localparam int unsigned POSIT_W = 16;
  localparam int unsigned FRAC_BITS = 60;
  localparam int unsigned Y_W = 62;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Special codes
  localparam logic [15:0] NAR_CODE = 16'h8000;
  localparam logic [15:0] MINPOS_CODE = 16'h0001;
  localparam logic [15:0] MAXPOS_CODE = 16'h7FFF;
  localparam logic [15:0] ONE_CODE = 16'h4000;
  localparam logic [15:0] LO_SAT_LAST = 16'h8F52;
  localparam logic [15:0] HI_SAT_FIRST = 16'h70AE;
  localparam logic [15:0] TINY_NEG_FIRST = 16'hFF80;
  localparam logic [15:0] TINY_POS_LAST = 16'h00BF;

  // log2(e) as a 53-bit integer times 2^-52
  localparam logic [52:0] LOG2E_MANT = 53'h17_1547_652B_82FE;

  // Powers of ten for building the coefficients at elaboration
  function automatic logic [319:0] pow10(input int unsigned p);
    logic [319:0] v;
    v = 320'd1;
    for (int unsigned i = 0; i < p; i++) begin
      v = v * 320'd10;
    end
    return v;
  endfunction

  localparam logic [319:0] C0_NUM =
    320'd0000001298120355652798707524198107421398162841796875;
  localparam logic [319:0] C1_NUM =
    320'd693141820259879803955982424668036401271820068359375;
  localparam logic [319:0] C2_NUM =
    320'd240286646236610668125877054990269243717193603515625;
  localparam logic [319:0] C3_NUM =
    320'd05522989323495941516029006379540078341960906982421875;
  localparam logic [319:0] C4_NUM =
    320'd01019728060416365440776775841413837042637169361114501953125;
  localparam logic [319:0] C5_NUM =
    320'd000756416228767151587429606873769216690561734139919281005859375;
  localparam logic [319:0] C6_NUM =
    320'd0003880795968797916273285153465621988289058208465576171875;

  // Horner coefficients, unsigned Q1.60, truncated
  localparam logic [60:0] C0_Q = 61'((C0_NUM << 60) / pow10(52)) + (61'd1 << 60);
  localparam logic [60:0] C1_Q = 61'((C1_NUM << 60) / pow10(51));
  localparam logic [60:0] C2_Q = 61'((C2_NUM << 60) / pow10(51));
  localparam logic [60:0] C3_Q = 61'((C3_NUM << 60) / pow10(53));
  localparam logic [60:0] C4_Q = 61'((C4_NUM << 60) / pow10(59));
  localparam logic [60:0] C5_Q = 61'((C5_NUM << 60) / pow10(63));
  localparam logic [60:0] C6_Q = 61'((C6_NUM << 60) / pow10(58));

  localparam logic [60:0] COEF_Q [7] = '{C0_Q, C1_Q, C2_Q, C3_Q, C4_Q, C5_Q, C6_Q};

  // Work item handed from front to back
  typedef struct packed {
    logic              special;
    logic [15:0]       spec_val;
    logic signed [7:0] n;
    logic [59:0]       fq;
  } pexp_job_t;

  // Queue status seen by the front, the back and the top level
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

// File: sv/pexp_if.sv
`default_nettype none
// Operand channel
interface pexp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] operand;
  modport source(output valid, output operand, input ready);
  modport sink(input valid, input operand, output ready);
endinterface

// Result channel
interface pexp_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result;
  modport source(output valid, output result, input ready);
  modport sink(input valid, input result, output ready);
endinterface
`default_nettype wire

// File: sv/pexp_front.sv
`default_nettype none
module pexp_front import pexp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic [15:0] in_operand,
  output logic             in_ready,
  input  wire q_stat_t     q_stat,
  output logic             push,
  output pexp_job_t        push_job
);

  logic adv;
  logic v1_r, v2_r, v3_r;

  // Stage 1 registers: decoded operand
  logic              special1_r;
  logic [15:0]       spec_val1_r;
  logic              neg1_r;
  logic signed [6:0] sc1_r;
  logic [12:0]       m1_r;

  // Stage 2 registers: scaled product
  logic              special2_r;
  logic [15:0]       spec_val2_r;
  logic              neg2_r;
  logic [6:0]        s2_r;
  logic [65:0]       prod2_r;

  // Stage 3 register: finished job
  pexp_job_t job3_r;

  // Decode signals
  logic              neg;
  logic [15:0]       pabs;
  logic [14:0]       b15;
  logic              lead;
  logic [14:0]       xr;
  logic [4:0]        r;
  logic signed [5:0] k;
  logic [14:0]       tail;
  logic signed [6:0] sc_raw;
  logic signed [6:0] sc_cl;
  logic              special;
  logic [15:0]       spec_val;

  // Split signals
  logic [79:0]       mask;
  logic [79:0]       frac;
  logic [79:0]       frac_neg;
  logic [79:0]       fr;
  logic              fnz;
  logic [5:0]        ip;
  logic [6:0]        fsh;
  logic signed [7:0] n_val;
  pexp_job_t         job_nxt;

  // Advance the front unless its last stage is held by a full queue
  assign adv = !v3_r || !q_stat.full;
  assign in_ready = adv;
  assign push = v3_r && !q_stat.full;
  assign push_job = job3_r;

  // Classify and decode the operand
  always_comb begin
    neg = in_operand[15];
    pabs = neg ? 16'(16'd0 - in_operand) : in_operand;
    b15 = pabs[14:0];
    lead = b15[14];
    xr = lead ? ~b15 : b15;
    r = 5'd15;
    for (int i = 0; i < 15; i++) begin
      if (xr[i]) begin
        r = 5'(14 - i);
      end
    end
    k = lead ? 6'($signed({1'b0, r}) - 6'sd1) : 6'(-$signed({1'b0, r}));
    tail = 15'({1'b0, b15} << (r + 5'd1));
    sc_raw = 7'(2 * k) + 7'({6'd0, tail[14]});
    if (sc_raw < -7'sd14) begin
      sc_cl = -7'sd14;
    end else if (sc_raw > 7'sd4) begin
      sc_cl = 7'sd4;
    end else begin
      sc_cl = sc_raw;
    end
    special = 1'b1;
    spec_val = ONE_CODE;
    if (in_operand == NAR_CODE) begin
      spec_val = NAR_CODE;
    end else if (in_operand > NAR_CODE && in_operand <= LO_SAT_LAST) begin
      spec_val = MINPOS_CODE;
    end else if (in_operand >= HI_SAT_FIRST && in_operand < NAR_CODE) begin
      spec_val = MAXPOS_CODE;
    end else if (in_operand >= TINY_NEG_FIRST || in_operand <= TINY_POS_LAST) begin
      spec_val = ONE_CODE;
    end else begin
      special = 1'b0;
    end
  end

  // Split x*log2(e) into integer part and Q0.60 fraction
  always_comb begin
    mask = (80'd1 << s2_r) - 80'd1;
    frac = {14'd0, prod2_r} & mask;
    fnz = |frac;
    frac_neg = (~frac + 80'd1) & mask;
    fr = neg2_r ? frac_neg : frac;
    fsh = s2_r - 7'd60;
    ip = 6'({14'd0, prod2_r} >> s2_r);
    if (!neg2_r) begin
      n_val = $signed({2'b00, ip});
    end else if (fnz) begin
      n_val = 8'(-$signed({2'b00, ip}) - 8'sd1);
    end else begin
      n_val = 8'(-$signed({2'b00, ip}));
    end
    job_nxt.special = special2_r;
    job_nxt.spec_val = spec_val2_r;
    job_nxt.n = n_val;
    job_nxt.fq = 60'(fr >> fsh);
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (adv) begin
      special1_r <= special;
      spec_val1_r <= spec_val;
      neg1_r <= neg;
      sc1_r <= sc_cl;
      m1_r <= {1'b1, tail[13:2]};
      special2_r <= special1_r;
      spec_val2_r <= spec_val1_r;
      neg2_r <= neg1_r;
      s2_r <= 7'(7'd64 - 7'(sc1_r));
      prod2_r <= 66'(m1_r) * 66'(LOG2E_MANT);
      job3_r <= job_nxt;
    end
  end

endmodule
`default_nettype wire

// File: sv/pexp_queue.sv
`default_nettype none
module pexp_queue import pexp_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire pexp_job_t push_job,
  input  wire logic      pop,
  output pexp_job_t      head,
  output q_stat_t        stat
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  pexp_job_t         entries_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [CW-1:0]     cnt_r;

  assign stat.full = (cnt_r == CW'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head = entries_r[rd_ptr_r];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_r + 1'b1);
      end
      if (push && !pop) begin
        cnt_r <= CW'(cnt_r + 1'b1);
      end else if (pop && !push) begin
        cnt_r <= CW'(cnt_r - 1'b1);
      end
    end
  end

  // Store item
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

// File: sv/pexp_step.sv
`default_nettype none
module pexp_step import pexp_pkg::*; #(
  parameter logic [60:0] COEF = C0_Q
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            adv,
  input  wire logic            in_valid,
  input  wire pexp_job_t       in_job,
  input  wire logic [Y_W-1:0]  in_y,
  output logic                 out_valid,
  output pexp_job_t            out_job,
  output logic [Y_W-1:0]       out_y
);

  logic            va_r, vb_r;
  pexp_job_t       joba_r, jobb_r;
  logic [63:0]     pp_ll_r;
  logic [59:0]     pp_lh_r;
  logic [61:0]     pp_hl_r;
  logic [57:0]     pp_hh_r;
  logic [Y_W-1:0]  yb_r;
  logic [127:0]    acc;
  logic [Y_W-1:0]  y_nxt;

  // Sum partial products, round half up to Q60, add coefficient
  always_comb begin
    acc = 128'(pp_ll_r) + (128'(pp_lh_r) << 32) + (128'(pp_hl_r) << 32)
        + (128'(pp_hh_r) << 64) + (128'd1 << 59);
    y_nxt = {1'b0, acc[120:60]} + {1'b0, COEF};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  // Partial products, then accumulated result
  always_ff @(posedge clk) begin
    if (adv) begin
      joba_r <= in_job;
      pp_ll_r <= 64'(in_y[31:0]) * 64'(in_job.fq[31:0]);
      pp_lh_r <= 60'(in_y[31:0]) * 60'(in_job.fq[59:32]);
      pp_hl_r <= 62'(in_y[61:32]) * 62'(in_job.fq[31:0]);
      pp_hh_r <= 58'(in_y[61:32]) * 58'(in_job.fq[59:32]);
      jobb_r <= joba_r;
      yb_r <= y_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_job = jobb_r;
  assign out_y = yb_r;

endmodule
`default_nettype wire

// File: sv/pexp_back.sv
`default_nettype none
module pexp_back import pexp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire q_stat_t   q_stat,
  input  wire pexp_job_t head,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic [15:0]    out_result
);

  localparam int unsigned STEPS = 6;

  logic            adv;
  logic            sv_w  [STEPS+1];
  pexp_job_t       sj_w  [STEPS+1];
  logic [Y_W-1:0]  sy_w  [STEPS+1];

  logic            out_valid_r;
  logic [15:0]     out_result_r;

  // Encoder signals
  pexp_job_t         ej;
  logic [Y_W-1:0]    ey;
  logic              b61;
  logic [60:0]       frac61;
  logic signed [8:0] t;
  logic signed [8:0] k;
  logic [3:0]        amt;
  logic [79:0]       zext;
  logic [79:0]       zsh;
  logic [14:0]       body;
  logic              rnd;
  logic [15:0]       bsum;
  logic [15:0]       res;
  logic [15:0]       enc;

  // Advance the whole back end when the output register frees up
  assign adv = !out_valid_r || out_ready;
  assign pop = adv && !q_stat.empty;

  assign sv_w[0] = !q_stat.empty;
  assign sj_w[0] = head;
  assign sy_w[0] = {1'b0, COEF_Q[6]};

  // Horner steps from the top coefficient down
  for (genvar j = 0; j < STEPS; j++) begin : g_step
    pexp_step #(.COEF(COEF_Q[STEPS - 1 - j])) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_valid  (sv_w[j]),
      .in_job    (sj_w[j]),
      .in_y      (sy_w[j]),
      .out_valid (sv_w[j+1]),
      .out_job   (sj_w[j+1]),
      .out_y     (sy_w[j+1])
    );
  end

  // Encode Y * 2^(n-60) as posit, round to nearest even, saturate
  always_comb begin
    ej = sj_w[STEPS];
    ey = sy_w[STEPS];
    b61 = ey[61];
    frac61 = b61 ? ey[60:0] : {ey[59:0], 1'b0};
    t = 9'(ej.n) + $signed({8'd0, b61});
    k = t >>> 1;
    amt = (k >= 0) ? k[3:0] : 4'(-k - 9'sd1);
    zext = {((k >= 0) ? 2'b10 : 2'b01), t[0], frac61, 16'd0};
    zsh = 80'($signed(zext) >>> amt);
    body = zsh[79:65];
    rnd = zsh[64] && ((|zsh[63:0]) || body[0]);
    bsum = {1'b0, body} + {15'd0, rnd};
    res = bsum[15] ? MAXPOS_CODE : bsum;
    if (res == 16'd0) begin
      res = MINPOS_CODE;
    end
    if (ej.special) begin
      enc = ej.spec_val;
    end else if (k >= 9'sd14) begin
      enc = MAXPOS_CODE;
    end else if (k < -9'sd14) begin
      enc = MINPOS_CODE;
    end else begin
      enc = res;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sv_w[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result_r <= enc;
    end
  end

  assign out_valid = out_valid_r;
  assign out_result = out_result_r;

endmodule
`default_nettype wire

// File: sv/posit16_exponential_core.sv
`default_nettype none
// Posit16 (es=1) exponential: returns the posit nearest to e^x, rounded to
// nearest even. NaR passes through; very negative inputs give minpos, very
// large ones maxpos, and inputs near zero give one. One operand is accepted
// every clock cycle when the result side keeps up. An item passes through
// 17 registers (3 decode/range-reduction stages, one queue slot, six Horner
// steps of two stages each for the 62x60-bit products, one encode stage),
// the first loaded at the accepting edge.
// The output register stalls the Horner pipeline only; the front keeps
// taking operands until the queue between them is full.
module posit16_exponential_core import pexp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pexp_in_if.sink     in_ch,
  pexp_out_if.source  out_ch
);

  q_stat_t   q_stat;
  logic      push;
  logic      pop;
  pexp_job_t push_job;
  pexp_job_t head;

  // Accept and reduce operands
  pexp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_operand (in_ch.operand),
    .in_ready   (in_ch.ready),
    .q_stat     (q_stat),
    .push       (push),
    .push_job   (push_job)
  );

  // Decouple front and back
  pexp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // Evaluate polynomial and encode
  pexp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_result (out_ch.result)
  );

`ifndef NO_ASSERTIONS
  // Front stalls only on a full queue
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> q_stat.full)
    else $error("input stalled while queue not full");

  // Reset empties the result side
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none
module tb_top;
  import pexp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RND_ITEMS = 1700;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam logic [52:0] LN2_INV_MANT = 53'h17_1547_652B_82FE;

  typedef enum logic [2:0] {
    IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_HOLD
  } idle_mode_t;

  typedef struct {
    logic [15:0] operand;
    logic        fixed;
    logic [15:0] result;
  } stim_row_t;

  logic clk;
  logic rst_n;
  pexp_in_if  in_if();
  pexp_out_if out_if();

  posit16_exponential_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if.sink), .out_ch(out_if.source)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  idle_mode_t  mode;
  logic [63:0] horner_coef [7];
  logic [15:0] exp_q [$];
  logic        lit_fixed_q [$];
  logic [15:0] lit_val_q [$];
  int unsigned n_errors;
  int unsigned n_in;
  int unsigned n_out;
  int unsigned quiet_cycles;
  bit          hold_req;

  // Truncate a decimal fraction string to Q60
  function automatic logic [63:0] digits_to_q60(input string d);
    logic [63:0] v;
    logic [63:0] dig;
    v = 64'd0;
    for (int i = d.len() - 1; i >= 0; i--) begin
      dig = 64'(d[i] - "0");
      v = ((dig << 60) + v) / 64'd10;
    end
    return v;
  endfunction

  // Product rounded half up to Q60
  function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] pr;
    pr = 128'(a) * 128'(b) + (128'd1 << 59);
    return 64'(pr >> 60);
  endfunction

  // Round Y * 2^(n-60) to the nearest posit, saturating
  function automatic logic [15:0] posit_round(input int n, input logic [63:0] y);
    int b, t, k, e, rl, p;
    logic [63:0] w, fr;
    logic [16:0] body;
    bit sticky;
    if (y == 0) return MINPOS_CODE;
    b = 63;
    while (y[b] == 1'b0) b--;
    t = n - 60 + b;
    k = (t >= 0) ? t / 2 : -((-t + 1) / 2);
    e = t - 2 * k;
    if (k >= 14) return MAXPOS_CODE;
    if (k < -14) return MINPOS_CODE;
    if (k >= 0) begin
      rl = k + 2;
      w = ((64'd1 << (k + 1)) - 64'd1) << (63 - (k + 1));
    end else begin
      rl = -k + 1;
      w = 64'd1 << (63 - rl);
    end
    p = 62 - rl;
    w |= 64'(e) << p;
    fr = (b > 0) ? (y & ((64'd1 << b) - 64'd1)) : 64'd0;
    sticky = 1'b0;
    if (b <= p) begin
      w |= fr << (p - b);
    end else begin
      w |= fr >> (b - p);
      sticky = (fr & ((64'd1 << (b - p)) - 64'd1)) != 0;
    end
    body = 17'((w >> 48) & 64'h7FFF);
    if ((w & ((64'd1 << 47) - 64'd1)) != 0) sticky = 1'b1;
    if (w[47] && (sticky || body[0])) body++;
    if (body > 17'h7FFF) body = 17'h7FFF;
    if (body == 0) body = 17'd1;
    return body[15:0];
  endfunction

  // Expected e^x for one posit operand
  function automatic logic [15:0] predict_exp(input logic [15:0] v);
    logic        neg, lead, fnz;
    logic [15:0] mag;
    logic [14:0] b15, rb;
    int r, k, rem, e, sc, s, n;
    logic [63:0]  m, fq, y;
    logic [127:0] pr, ip, mask, fracv;
    if (v == NAR_CODE) return NAR_CODE;
    if (v > NAR_CODE && v <= LO_SAT_LAST) return MINPOS_CODE;
    if (v >= HI_SAT_FIRST && v < NAR_CODE) return MAXPOS_CODE;
    if (v >= TINY_NEG_FIRST || v <= TINY_POS_LAST) return ONE_CODE;
    neg = v[15];
    mag = neg ? -v : v;
    b15 = mag[14:0];
    lead = b15[14];
    r = 0;
    while (r < 15 && b15[14 - r] == lead) r++;
    k = lead ? r - 1 : -r;
    rem = (r < 15) ? 14 - r : 0;
    rb = b15 & ((15'd1 << rem) - 15'd1);
    e = 0;
    m = 64'd4096;
    if (rem >= 1) begin
      e = int'(rb[rem - 1]);
      m = 64'd4096 | (64'(rb & ((15'd1 << (rem - 1)) - 15'd1)) << (13 - rem));
    end
    sc = 2 * k + e;
    if (sc < -14) sc = -14;
    if (sc > 4) sc = 4;
    // Range reduction: x*log2(e) = n + f
    pr = 128'(m) * 128'(LN2_INV_MANT);
    s = 64 - sc;
    ip = pr >> s;
    mask = (128'd1 << s) - 128'd1;
    fracv = pr & mask;
    fnz = fracv != 0;
    if (!neg) begin
      n = int'(ip[7:0]);
    end else if (fnz) begin
      n = -int'(ip[7:0]) - 1;
      fracv = (-fracv) & mask;
    end else begin
      n = -int'(ip[7:0]);
    end
    fq = 64'(fracv >> (s - 60));
    // Horner evaluation of 2^f
    y = horner_coef[6];
    for (int i = 5; i >= 0; i--) y = q60_mul(y, fq) + horner_coef[i];
    return posit_round(n, y);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    n_errors++;
  endtask

  // Predict on input accept, compare on output accept
  always @(posedge clk) begin
    logic [15:0] want;
    if (rst_n) begin
      if (in_if.valid && in_if.ready) begin
        want = predict_exp(in_if.operand);
        if (lit_fixed_q.size() > 0) begin
          if (lit_fixed_q.pop_front()) want = lit_val_q[0];
          void'(lit_val_q.pop_front());
        end
        exp_q.push_back(want);
        n_in++;
      end
      if (out_if.valid && out_if.ready) begin
        n_out++;
        if (exp_q.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing pending", out_if.result));
        end else begin
          want = exp_q.pop_front();
          if (out_if.result !== want)
            report_mismatch($sformatf("result %h, want %h", out_if.result, want));
        end
      end
    end
  end

  // Drive result-side ready; a hold request stalls for a long stretch
  always @(posedge clk) begin
    int unsigned held;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_req && held < HOLD_CYCLES) begin
      out_if.ready <= 1'b0;
      held++;
    end else begin
      if (!hold_req) held = 0;
      case (mode)
        IDLE_RECV: out_if.ready <= ($urandom_range(99) >= 58);
        IDLE_BOTH: out_if.ready <= ($urandom_range(99) >= 9);
        default:   out_if.ready <= 1'b1;
      endcase
    end
  end

  // Watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress in %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one item, with optional idle cycles ahead of it
  task automatic send_item(input logic [15:0] op, input logic fixed, input logic [15:0] lit);
    int unsigned pct;
    pct = (mode == IDLE_SEND) ? 58 : (mode == IDLE_BOTH) ? 9 : 0;
    while ($urandom_range(99) < pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    lit_fixed_q.push_back(fixed);
    lit_val_q.push_back(lit);
    in_if.valid <= 1'b1;
    in_if.operand <= op;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  stim_row_t directed [22] = '{
    '{16'h8000, 1'b1, 16'h8000}, '{16'h8001, 1'b1, 16'h0001},
    '{16'h8F52, 1'b1, 16'h0001}, '{16'h70AE, 1'b1, 16'h7FFF},
    '{16'h7FFF, 1'b1, 16'h7FFF}, '{16'hFF80, 1'b1, 16'h4000},
    '{16'hFFFF, 1'b1, 16'h4000}, '{16'h0000, 1'b1, 16'h4000},
    '{16'h00BF, 1'b1, 16'h4000}, '{16'h8F53, 1'b0, 16'h0},
    '{16'h70AD, 1'b0, 16'h0},    '{16'hFF7F, 1'b0, 16'h0},
    '{16'h00C0, 1'b0, 16'h0},    '{16'h4000, 1'b0, 16'h0},
    '{16'hC000, 1'b0, 16'h0},    '{16'h0100, 1'b0, 16'h0},
    '{16'h5555, 1'b0, 16'h0},    '{16'hAAAA, 1'b0, 16'h0},
    '{16'h7000, 1'b0, 16'h0},    '{16'h9000, 1'b0, 16'h0},
    '{16'h3FFF, 1'b0, 16'h0},    '{16'hF000, 1'b0, 16'h0}
  };

  idle_mode_t plan [5] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_HOLD};

  initial begin
    string digs [7];
    int unsigned drain;
    digs = '{
      "0000001298120355652798707524198107421398162841796875",
      "693141820259879803955982424668036401271820068359375",
      "240286646236610668125877054990269243717193603515625",
      "05522989323495941516029006379540078341960906982421875",
      "01019728060416365440776775841413837042637169361114501953125",
      "000756416228767151587429606873769216690561734139919281005859375",
      "0003880795968797916273285153465621988289058208465576171875"};
    for (int i = 0; i < 7; i++) horner_coef[i] = digits_to_q60(digs[i]);
    horner_coef[0] += 64'd1 << 60;
    n_errors = 0;
    n_in = 0;
    n_out = 0;
    hold_req = 1'b0;
    mode = IDLE_NONE;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.operand = 16'h0;
    out_if.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (directed[i]) send_item(directed[i].operand, directed[i].fixed, directed[i].result);

    // Random operands over every idle phase
    foreach (plan[ph]) begin
      mode = plan[ph];
      if (mode == IDLE_HOLD) hold_req = 1'b1;
      for (int unsigned i = 0; i < RND_ITEMS / 5; i++)
        send_item(16'($urandom_range(16'hFFFF)), 1'b0, 16'h0);
      hold_req = 1'b0;
    end
    in_if.valid <= 1'b0;
    mode = IDLE_NONE;

    // Drain
    drain = 0;
    while (exp_q.size() != 0) @(posedge clk);
    while (drain < DRAIN_CYCLES) begin
      @(posedge clk);
      drain++;
    end

    $display("covered %0d operands (special ranges, NaR, polynomial path), %0d results",
             n_in, n_out);
    $display("idle phases: none, sender, receiver, both, long receiver hold");
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
sv/pexp_pkg.sv
sv/pexp_if.sv
sv/pexp_front.sv
sv/pexp_queue.sv
sv/pexp_step.sv
sv/pexp_back.sv
sv/posit16_exponential_core.sv
bench/tb_top.sv
